@@ hdl/tcw_pkg.sv @@
package tcw_pkg;

   // Default screen store geometry
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 64;

   // Cell contents and reset values
   localparam logic [15:0] BLANK_CELL    = 16'h0700;
   localparam logic [7:0]  RESET_COLOUR  = 8'h07;
   localparam logic [7:0]  RESET_COLUMNS = 8'd80;
   localparam logic [6:0]  RESET_ROWS    = 7'd25;

   // Stream bytes with a meaning of their own
   localparam logic [7:0] CH_NL      = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_BS      = 8'd8;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_ESC     = 8'd27;
   localparam logic [7:0] ESC_CLEAR  = 8'd33;
   localparam logic [7:0] ESC_COLOUR = 8'd34;
   localparam logic [7:0] ESC_CURSOR = 8'd35;

   // Item commands
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;
   localparam logic [1:0] CSR_OUT_EN  = 2'd2;

   typedef struct packed {
      logic       cmd;
      logic [7:0] in_byte;
      logic       end_of_buffer;
      logic [5:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
      logic [7:0]  cursor_col;
      logic [6:0]  cursor_row;
      logic [13:0] cursor_linear;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic rd_item;
      logic act;
      logic swp_clr;
      logic copy;
      logic fill;
      logic row_dec;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic put_en;
      logic pre_scroll;
      logic act_scroll;
      logic act_clear;
      logic copy_done;
      logic fill_last_area;
      logic fill_last_full;
   } ctrl_status_type;

endpackage

@@ hdl/tcw_ctrl.sv @@
module tcw_ctrl import tcw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  ctrl_status_type sts,
   output ctrl_cmd_type    cmd
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_COPY   = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_ACT    = 3'd5;
   localparam logic [2:0] S_CLEAR  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       post_ff, post_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Clear the store after reset, then sequence each word through decode, scroll, action, clear and result
   always_comb begin
      state_in = state_ff;
      post_in  = post_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.fill = 1'b1;
            if (sts.fill_last_full) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_read) begin
               cmd.rd_item = 1'b1;
               state_in    = S_DONE;
            end else if (!sts.put_en) begin
               state_in = S_DONE;
            end else if (sts.pre_scroll) begin
               cmd.swp_clr = 1'b1;
               post_in     = 1'b0;
               state_in    = S_COPY;
            end else begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            cmd.act = 1'b1;
            if (sts.act_clear) begin
               cmd.swp_clr = 1'b1;
               state_in    = S_CLEAR;
            end else if (sts.act_scroll) begin
               cmd.swp_clr = 1'b1;
               post_in     = 1'b1;
               state_in    = S_COPY;
            end else begin
               state_in = S_DONE;
            end
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            if (sts.copy_done) state_in = S_FILL;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_last_area) begin
               cmd.row_dec = 1'b1;
               state_in    = post_ff ? S_DONE : S_ACT;
            end
         end
         S_CLEAR: begin
            cmd.fill = 1'b1;
            if (sts.fill_last_area) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         post_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         post_ff      <= post_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/tcw_dp.sv @@
module tcw_dp import tcw_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_wdata,
   input  req_type         req_data,
   output rsp_type         rsp_data,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type sts
);

   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int AREA_W = $clog2(DEPTH + 1);
   localparam int LIN_W  = ROW_W + COL_W + 1;

   localparam logic [2:0] PH_TEXT   = 3'd0;
   localparam logic [2:0] PH_ESC    = 3'd1;
   localparam logic [2:0] PH_COLOUR = 3'd2;
   localparam logic [2:0] PH_XARG   = 3'd3;
   localparam logic [2:0] PH_YARG   = 3'd4;

   logic [7:0]        columns_ff, columns_in;
   logic [6:0]        rows_ff, rows_in;
   logic              oe_ff, oe_in;
   req_type           item_ff;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [7:0]        colour_ff, colour_in;
   logic [2:0]        phase_ff, phase_in;
   logic [COL_W-1:0]  pend_ff, pend_in;
   logic [AREA_W-1:0] area_ff, body_ff;
   logic [AREA_W-1:0] swp_ff, swp_in;
   logic              pipe_v_ff;
   logic [ADDR_W-1:0] pipe_addr_ff;
   logic [15:0]       mem [DEPTH];
   logic [15:0]       mem_q_ff;
   logic              rd_ok_ff;
   rsp_type           rsp_ff;

   logic [COL_W-1:0]  cols;
   logic [ROW_W-1:0]  nrows;
   logic [8:0]        c9;
   logic [7:0]        r8;
   logic [7:0]        b;

   // Clamp the geometry registers to the supported range
   always_comb begin
      c9 = {1'b0, columns_ff};
      r8 = {1'b0, rows_ff};
      if (c9 < 9'd8) c9 = 9'd8;
      if (c9 > 9'(MAX_COLUMNS)) c9 = 9'(MAX_COLUMNS);
      if (r8 < 8'd1) r8 = 8'd1;
      if (r8 > 8'(MAX_ROWS)) r8 = 8'(MAX_ROWS);
      cols  = COL_W'(c9);
      nrows = ROW_W'(r8);
   end

   assign b = item_ff.in_byte;

   // Configuration writes
   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      oe_in      = oe_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COLUMNS: columns_in = csr_wdata;
            CSR_ROWS:    rows_in    = csr_wdata[6:0];
            CSR_OUT_EN:  oe_in      = csr_wdata[0];
            default:     ;
         endcase
      end
   end

   // Action of one stream byte
   logic [COL_W-1:0] a_col;
   logic [ROW_W-1:0] a_row;
   logic [7:0]       a_colour;
   logic [2:0]       a_phase;
   logic [COL_W-1:0] a_pend;
   logic             wr_en;
   logic [ROW_W-1:0] wr_row;
   logic [COL_W-1:0] wr_col;
   logic [7:0]       wr_char;
   logic             scroll_req, clear_req;
   logic [COL_W:0]   tab_sum;

   always_comb begin
      a_col      = cur_col_ff;
      a_row      = cur_row_ff;
      a_colour   = colour_ff;
      a_phase    = phase_ff;
      a_pend     = pend_ff;
      wr_en      = 1'b0;
      wr_row     = cur_row_ff;
      wr_col     = cur_col_ff;
      wr_char    = b;
      scroll_req = 1'b0;
      clear_req  = 1'b0;
      tab_sum    = (COL_W+1)'({cur_col_ff[COL_W-1:3], 3'b000}) + (COL_W+1)'(8);
      case (phase_ff)
         PH_TEXT: begin
            if (b == CH_ESC) begin
               a_phase = PH_ESC;
            end else if (b == CH_NL) begin
               a_col      = '0;
               a_row      = cur_row_ff + 1'b1;
               scroll_req = (a_row == nrows);
            end else if (b == CH_CR) begin
               a_col = '0;
            end else if (b == CH_BS) begin
               if (cur_col_ff != '0 || cur_row_ff != '0) begin
                  if (cur_col_ff == '0) begin
                     a_row = cur_row_ff - 1'b1;
                     a_col = cols - 1'b1;
                  end else begin
                     a_col = cur_col_ff - 1'b1;
                  end
                  wr_en   = 1'b1;
                  wr_row  = a_row;
                  wr_col  = a_col;
                  wr_char = '0;
               end
            end else if (b == CH_TAB) begin
               if (tab_sum >= (COL_W+1)'(cols)) begin
                  a_row      = cur_row_ff + 1'b1;
                  a_col      = COL_W'(tab_sum - (COL_W+1)'(cols));
                  scroll_req = (a_row == nrows);
               end else begin
                  a_col = COL_W'(tab_sum);
               end
            end else begin
               wr_en = 1'b1;
               if (cur_col_ff + 1'b1 == cols) begin
                  a_col = '0;
                  a_row = cur_row_ff + 1'b1;
               end else begin
                  a_col = cur_col_ff + 1'b1;
               end
            end
         end
         PH_ESC: begin
            a_phase = PH_TEXT;
            if (b == ESC_CLEAR) begin
               clear_req = 1'b1;
               a_col     = '0;
               a_row     = '0;
               a_colour  = RESET_COLOUR;
            end else if (b == ESC_COLOUR) begin
               a_phase = PH_COLOUR;
            end else if (b == ESC_CURSOR) begin
               a_phase = PH_XARG;
            end
         end
         PH_COLOUR: begin
            a_colour = b;
            a_phase  = PH_TEXT;
         end
         PH_XARG: begin
            a_pend  = (9'(b) >= 9'(cols)) ? '0 : COL_W'(b);
            a_phase = PH_YARG;
         end
         default: begin
            a_col   = pend_ff;
            a_row   = (b >= 8'(nrows)) ? '0 : ROW_W'(b);
            a_phase = PH_TEXT;
         end
      endcase
      if (item_ff.end_of_buffer) a_phase = PH_TEXT;
   end

   // Shared row times columns plus column
   logic [LIN_W-1:0] m_row, m_col, lin;
   always_comb begin
      if (cmd.rd_item) begin
         m_row = LIN_W'(item_ff.read_row);
         m_col = LIN_W'(item_ff.read_col);
      end else if (cmd.act) begin
         m_row = LIN_W'(wr_row);
         m_col = LIN_W'(wr_col);
      end else begin
         m_row = LIN_W'(cur_row_ff);
         m_col = LIN_W'(cur_col_ff);
      end
      lin = m_row * LIN_W'(cols) + m_col;
   end

   // Cursor, colour and parser state
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      colour_in  = colour_ff;
      phase_in   = phase_ff;
      pend_in    = pend_ff;
      if (cmd.load && req_data.cmd == CMD_PUT && oe_ff) begin
         if (cur_col_ff >= cols) cur_col_in = '0;
         if (cur_row_ff > nrows) cur_row_in = '0;
      end
      if (cmd.act) begin
         cur_col_in = a_col;
         cur_row_in = a_row;
         colour_in  = a_colour;
         phase_in   = a_phase;
         pend_in    = a_pend;
      end
      if (cmd.row_dec && cur_row_ff != '0) cur_row_in = cur_row_ff - 1'b1;
   end

   // Sweep counter for scroll, clear and the clearing pass after reset
   logic copy_rd;
   assign copy_rd = cmd.copy && (swp_ff < body_ff);

   always_comb begin
      swp_in = swp_ff;
      if (cmd.swp_clr) swp_in = '0;
      else if (copy_rd || cmd.fill) swp_in = swp_ff + 1'b1;
   end

   // Screen store ports
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [15:0]       mem_wd;
   logic [AREA_W-1:0] src_addr;

   assign src_addr = swp_ff + AREA_W'(cols);

   always_comb begin
      mem_we = (cmd.act && wr_en) || pipe_v_ff || cmd.fill;
      if (cmd.act) begin
         mem_wa = lin[ADDR_W-1:0];
         mem_wd = {colour_ff, wr_char};
      end else if (pipe_v_ff) begin
         mem_wa = pipe_addr_ff;
         mem_wd = mem_q_ff;
      end else begin
         mem_wa = swp_ff[ADDR_W-1:0];
         mem_wd = BLANK_CELL;
      end
      mem_re = cmd.rd_item || copy_rd;
      mem_ra = cmd.rd_item ? lin[ADDR_W-1:0] : src_addr[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) mem_q_ff <= mem[mem_ra];
   end

   // Status toward the controller
   always_comb begin
      sts.is_read        = (item_ff.cmd == CMD_READ);
      sts.put_en         = oe_ff;
      sts.pre_scroll     = (phase_ff == PH_TEXT) && (b != CH_ESC) && (cur_row_ff == nrows);
      sts.act_scroll     = scroll_req;
      sts.act_clear      = clear_req;
      sts.copy_done      = (swp_ff >= body_ff) && !pipe_v_ff;
      sts.fill_last_area = (swp_ff == area_ff - 1'b1);
      sts.fill_last_full = (swp_ff == AREA_W'(DEPTH - 1));
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      area_ff      <= AREA_W'(AREA_W'(cols) * AREA_W'(nrows));
      body_ff      <= area_ff - AREA_W'(cols);
      pipe_addr_ff <= swp_ff[ADDR_W-1:0];
      if (cmd.rd_item) begin
         rd_ok_ff <= (8'(item_ff.read_row) < 8'(nrows)) &&
                     (9'(item_ff.read_col) < 9'(cols));
      end
      if (cmd.rsp_load) begin
         if (item_ff.cmd == CMD_READ && rd_ok_ff) begin
            rsp_ff.cell_char <= mem_q_ff[7:0];
            rsp_ff.cell_attr <= mem_q_ff[15:8];
         end else begin
            rsp_ff.cell_char <= '0;
            rsp_ff.cell_attr <= '0;
         end
         rsp_ff.cursor_col    <= 8'(cur_col_ff);
         rsp_ff.cursor_row    <= 7'(cur_row_ff);
         rsp_ff.cursor_linear <= 14'(lin);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= RESET_COLUMNS;
         rows_ff    <= RESET_ROWS;
         oe_ff      <= 1'b1;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         colour_ff  <= RESET_COLOUR;
         phase_ff   <= PH_TEXT;
         pend_ff    <= '0;
         swp_ff     <= '0;
         pipe_v_ff  <= 1'b0;
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
         oe_ff      <= oe_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         colour_ff  <= colour_in;
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         swp_ff     <= swp_in;
         pipe_v_ff  <= copy_rd;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hdl/text_console_writer_unit.sv @@
// Text terminal engine over a character/attribute screen store of MAX_COLUMNS x MAX_ROWS
// cells. After reset all MAX_COLUMNS*MAX_ROWS cells (8192 by default) are cleared, one
// cell a cycle, before the first word is taken. Words are handled one at a time and each
// gives one result word. A read word, or a put word while output is disabled, passes
// accept, decode and result; every other put byte passes accept, decode, one action step
// with at most one store write, and result. A scroll walks the store through its single
// read and write port, moving rows up one and blanking the last; a newline on a pending
// wrap scrolls twice, as does a tab on an 8-column screen. ESC 33 blanks columns*rows
// cells, one a cycle. The next word is taken while a result still waits.
module text_console_writer_unit import tcw_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

@@ tb/sv/text_console_writer_unit_tb.sv @@
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
   import tcw_pkg::*;

   localparam int STORE_DEPTH = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
   localparam int STALL_LIMIT = 60000;

   typedef enum logic [2:0] {SEQ_TEXT, SEQ_ESC, SEQ_COLOUR, SEQ_XARG, SEQ_YARG} seq_phase_type;

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type e;
   } word_entry_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = CSR_COLUMNS;
   logic [7:0] csr_wdata = '0;

   // Predicted terminal state
   logic [15:0]   screen_mirror [STORE_DEPTH];
   int            cur_col, cur_row, pend_col;
   logic [7:0]    cur_colour;
   seq_phase_type seq_phase;
   logic [7:0]    reg_columns;
   logic [6:0]    reg_rows;
   logic          reg_out_en;

   word_entry_type word_q[$];
   word_entry_type next_entry;
   rsp_type        cell_expect_q[$];
   rsp_type        want, got;

   int  mismatches = 0;
   int  gap_left = 0, stall_left = 0, quiet_cnt = 0;
   bit  calm_send = 0, calm_recv = 0;
   bit  take_req, take_rsp;

   text_console_writer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int used_columns();
      if (reg_columns < 8) return 8;
      if (reg_columns > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
      return reg_columns;
   endfunction

   function automatic int used_rows();
      if (reg_rows < 1) return 1;
      if (reg_rows > DEF_MAX_ROWS) return DEF_MAX_ROWS;
      return reg_rows;
   endfunction

   function automatic void write_cell(int r, int c, int cols, logic [7:0] ch);
      int idx;
      idx = r * cols + c;
      if (idx < STORE_DEPTH) screen_mirror[idx] = {cur_colour, ch};
   endfunction

   // Shift rows up and blank the bottom one
   function automatic void scroll_screen(int cols, int nrows);
      int n;
      n = cols * (nrows - 1);
      for (int i = 0; i < n; i++) screen_mirror[i] = screen_mirror[i + cols];
      for (int i = n; i < n + cols; i++) screen_mirror[i] = BLANK_CELL;
      if (cur_row > 0) cur_row--;
   endfunction

   function automatic void place_byte(logic [7:0] b, int cols, int nrows);
      if (cur_row == nrows) scroll_screen(cols, nrows);
      if (b == CH_NL) begin
         cur_col = 0;
         cur_row++;
         if (cur_row == nrows) scroll_screen(cols, nrows);
      end else if (b == CH_CR) begin
         cur_col = 0;
      end else if (b == CH_BS) begin
         // top-left cell: nothing moves, nothing blanks
         if (cur_col != 0 || cur_row != 0) begin
            if (cur_col == 0) begin
               cur_row--;
               cur_col = cols;
            end
            cur_col--;
            write_cell(cur_row, cur_col, cols, 8'h00);
         end
      end else if (b == CH_TAB) begin
         cur_col = (cur_col / 8 + 1) * 8;
         if (cur_col >= cols) begin
            cur_row++;
            cur_col -= cols;
            if (cur_row == nrows) scroll_screen(cols, nrows);
         end
      end else begin
         write_cell(cur_row, cur_col, cols, b);
         cur_col++;
         if (cur_col == cols) begin
            cur_col = 0;
            cur_row++;
         end
      end
   endfunction

   function automatic rsp_type predict_console(req_type r);
      int      cols, nrows;
      rsp_type o;
      cols  = used_columns();
      nrows = used_rows();
      o = '0;
      if (r.cmd == CMD_READ) begin
         if (r.read_row < nrows && r.read_col < cols) begin
            o.cell_char = screen_mirror[r.read_row * cols + r.read_col][7:0];
            o.cell_attr = screen_mirror[r.read_row * cols + r.read_col][15:8];
         end
      end else if (reg_out_en) begin
         if (cur_col >= cols) cur_col = 0;
         if (cur_row > nrows) cur_row = 0;
         case (seq_phase)
            SEQ_TEXT: begin
               if (r.in_byte == CH_ESC) seq_phase = SEQ_ESC;
               else place_byte(r.in_byte, cols, nrows);
            end
            SEQ_ESC: begin
               seq_phase = SEQ_TEXT;
               if (r.in_byte == ESC_CLEAR) begin
                  cur_col = 0;
                  cur_row = 0;
                  cur_colour = RESET_COLOUR;
                  for (int i = 0; i < cols * nrows && i < STORE_DEPTH; i++)
                     screen_mirror[i] = BLANK_CELL;
               end else if (r.in_byte == ESC_COLOUR) begin
                  seq_phase = SEQ_COLOUR;
               end else if (r.in_byte == ESC_CURSOR) begin
                  seq_phase = SEQ_XARG;
               end
            end
            SEQ_COLOUR: begin
               cur_colour = r.in_byte;
               seq_phase = SEQ_TEXT;
            end
            SEQ_XARG: begin
               pend_col = (r.in_byte >= cols) ? 0 : r.in_byte;
               seq_phase = SEQ_YARG;
            end
            default: begin
               cur_col = pend_col;
               cur_row = (r.in_byte >= nrows) ? 0 : r.in_byte;
               seq_phase = SEQ_TEXT;
            end
         endcase
         if (r.end_of_buffer) seq_phase = SEQ_TEXT;
      end
      o.cursor_col    = cur_col[7:0];
      o.cursor_row    = cur_row[6:0];
      o.cursor_linear = 14'(cur_row * cols + cur_col);
      return o;
   endfunction

   function automatic req_type mk_word(logic c, logic [7:0] b, logic eob,
                                       logic [5:0] rr, logic [6:0] rc);
      req_type r;
      r.cmd = c;
      r.in_byte = b;
      r.end_of_buffer = eob;
      r.read_row = rr;
      r.read_col = rc;
      return r;
   endfunction

   function automatic rsp_type mk_cell(logic [7:0] ch, logic [7:0] at, logic [7:0] col,
                                       logic [6:0] row, logic [13:0] lin);
      rsp_type e;
      e.cell_char = ch;
      e.cell_attr = at;
      e.cursor_col = col;
      e.cursor_row = row;
      e.cursor_linear = lin;
      return e;
   endfunction

   function automatic void add_word(req_type r, bit fixed = 0, rsp_type e = '0);
      word_entry_type w;
      w.r = r;
      w.fixed = fixed;
      w.e = e;
      word_q.push_back(w);
   endfunction

   function automatic void add_put(logic [7:0] b, logic eob = 0);
      add_word(mk_word(CMD_PUT, b, eob, 6'($urandom), 7'($urandom)));
   endfunction

   function automatic int pick_near(int lim, int hi);
      if ($urandom_range(0, 3) != 0) return $urandom_range(0, lim - 1);
      return $urandom_range(0, hi);
   endfunction

   // Random word stream: reads, mostly well-formed escapes and text, some noise
   function automatic void gen_stream(int n, int cols, int nrows);
      int k, cnt;
      logic [7:0] ctl [4];
      ctl = '{CH_NL, CH_CR, CH_BS, CH_TAB};
      cnt = 0;
      while (cnt < n) begin
         k = $urandom_range(0, 99);
         if (k < 25) begin
            add_word(mk_word(CMD_READ, 8'($urandom), 1'($urandom),
                             6'(pick_near(nrows, 63)), 7'(pick_near(cols, 127))));
            cnt++;
         end else if (k < 55) begin
            add_put(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126)),
                    $urandom_range(0, 19) == 0);
            cnt++;
         end else if (k < 70) begin
            add_put(ctl[$urandom_range(0, 3)], $urandom_range(0, 19) == 0);
            cnt++;
         end else if (k < 90) begin
            add_put(CH_ESC, $urandom_range(0, 24) == 0);
            k = $urandom_range(0, 9);
            if (k < 2) begin
               add_put(ESC_CLEAR);
               cnt += 2;
            end else if (k < 5) begin
               add_put(ESC_COLOUR);
               add_put(8'($urandom), $urandom_range(0, 9) == 0);
               cnt += 3;
            end else if (k < 9) begin
               add_put(ESC_CURSOR, $urandom_range(0, 24) == 0);
               add_put(8'(pick_near(cols + 1, 255)));
               add_put(8'(pick_near(nrows + 1, 255)));
               cnt += 4;
            end else begin
               add_put(8'($urandom));
               cnt += 2;
            end
         end else begin
            add_word(mk_word(1'($urandom), 8'($urandom), 1'($urandom),
                             6'($urandom), 7'($urandom)));
            cnt++;
         end
      end
   endfunction

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Drive the request side, take results, keep the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         take_req = req_valid && !req_stall;
         take_rsp = rsp_valid && !rsp_stall;

         // predict the word the block just took
         if (take_req) begin
            want = predict_console(req_data);
            if (next_entry.fixed) want = next_entry.e;
            cell_expect_q.push_back(want);
         end

         // compare the result word
         if (take_rsp) begin
            got = rsp_data;
            if (cell_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
               want = cell_expect_q.pop_front();
               if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
                   got.cursor_col !== want.cursor_col ||
                   got.cursor_row !== want.cursor_row ||
                   got.cursor_linear !== want.cursor_linear) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: char %h/%h attr %h/%h col %0d/%0d row %0d/%0d lin %0d/%0d",
                              want.cell_char, got.cell_char, want.cell_attr, got.cell_attr,
                              want.cursor_col, got.cursor_col, want.cursor_row,
                              got.cursor_row, want.cursor_linear, got.cursor_linear);
               end
            end
         end

         // next request word, holding a stalled one
         if (!(req_valid && req_stall)) begin
            if ($urandom_range(0, 199) == 0) calm_send = !calm_send;
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (word_q.size() > 0) begin
               next_entry = word_q.pop_front();
               req_valid <= 1'b1;
               req_data  <= next_entry.r;
               gap_left = calm_send ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end

         // random result stall
         if ($urandom_range(0, 199) == 0) calm_recv = !calm_recv;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = calm_recv ? 0 : pick_gap();
            rsp_stall <= (stall_left > 0);
         end

         // watchdog over cycles with work pending and nothing moving
         if ((word_q.size() > 0 || req_valid || cell_expect_q.size() > 0) &&
             !take_req && !take_rsp)
            quiet_cnt++;
         else
            quiet_cnt = 0;
         if (quiet_cnt >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (word_q.size() == 0 && !req_valid && cell_expect_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(logic [7:0] cols, logic [6:0] nrows, logic oe, int n);
      wait_idle();
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROWS, {1'b0, nrows});
      write_reg(CSR_OUT_EN, {7'd0, oe});
      reg_columns = cols;
      reg_rows = nrows;
      reg_out_en = oe;
      gen_stream(n, used_columns(), used_rows());
   endtask

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) screen_mirror[i] = BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
      pend_col = 0;
      cur_colour = RESET_COLOUR;
      seq_phase = SEQ_TEXT;
      reg_columns = RESET_COLUMNS;
      reg_rows = RESET_ROWS;
      reg_out_en = 1'b1;
      next_entry.fixed = 0;

      // directed words on the reset geometry of 80 x 25
      add_word(mk_word(CMD_READ, 8'h00, 0, 6'd0, 7'd0), 1, mk_cell(8'h00, 8'h07, 0, 0, 0));
      add_word(mk_word(CMD_READ, 8'hFF, 1, 6'd63, 7'd127), 1, mk_cell(0, 0, 0, 0, 0));
      add_word(mk_word(CMD_PUT, 8'h41, 0, 6'd63, 7'd127), 1, mk_cell(0, 0, 1, 0, 1));
      add_put(8'hFF);
      add_put(8'h00);
      add_put(CH_TAB);
      add_put(CH_BS);
      add_put(CH_NL);
      add_put(CH_CR);
      add_put(CH_ESC);
      add_put(ESC_COLOUR);
      add_put(8'hFF);
      add_put(8'h5A);
      add_put(CH_ESC);
      add_put(ESC_CURSOR);
      add_put(8'd200);
      add_word(mk_word(CMD_PUT, 8'd200, 0, 0, 0), 1, mk_cell(0, 0, 0, 0, 0));
      add_put(CH_BS);
      add_put(CH_ESC);
      add_put(ESC_CURSOR);
      add_put(8'd79);
      add_put(8'd24);
      add_word(mk_word(CMD_PUT, 8'h78, 0, 0, 0), 1, mk_cell(0, 0, 0, 25, 14'd2000));
      add_put(8'h79);
      add_word(mk_word(CMD_READ, 8'h00, 0, 6'd23, 7'd79));
      add_put(CH_ESC, 1);
      add_put(ESC_CLEAR);
      add_put(CH_ESC);
      add_put(8'd99);
      add_put(CH_ESC);
      add_word(mk_word(CMD_PUT, ESC_CLEAR, 0, 0, 0), 1, mk_cell(0, 0, 0, 0, 0));
      add_word(mk_word(CMD_READ, 8'h00, 0, 6'd0, 7'd0), 1, mk_cell(8'h00, 8'h07, 0, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_phase(8'd8, 7'd1, 1'b1, 200);
      run_phase(8'd16, 7'd4, 1'b1, 250);
      run_phase(8'd0, 7'd0, 1'b1, 100);
      run_phase(8'd128, 7'd64, 1'b1, 40);
      run_phase(8'd12, 7'd3, 1'b0, 80);
      run_phase(8'd255, 7'd127, 1'b1, 40);
      run_phase(8'd20, 7'd5, 1'b1, 250);
      run_phase(8'd40, 7'd8, 1'b1, 200);
      run_phase(8'd9, 7'd2, 1'b1, 100);

      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/tcw_pkg.sv
hdl/tcw_ctrl.sv
hdl/tcw_dp.sv
hdl/text_console_writer_unit.sv
tb/sv/text_console_writer_unit_tb.sv
